// ===== hw/rtl/diusc_pkg.sv =====
`default_nettype none
package diusc_pkg;

  // Partition address width; routed byte counter carries one extra bit for "full".
  localparam int PART_ADDR_BITS = 24;
  localparam int ROUTE_W        = PART_ADDR_BITS + 1;
  localparam int OFFSET_W       = 24;

  localparam int          HDR_BYTES = 56;
  localparam int          HDR_POS_W = 6;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // Header word slots (byte position / 4)
  localparam logic [3:0] WORD_CHK_A = 4'd4;
  localparam logic [3:0] WORD_LEN_A = 4'd5;
  localparam logic [3:0] WORD_CHK_B = 4'd10;
  localparam logic [3:0] WORD_LEN_B = 4'd11;
  localparam logic [3:0] WORD_OFF_B = 4'd12;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_FINISH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HDR_BAD  = 2'd1,
    ST_CRC_ZERO = 2'd2,
    ST_SUM_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic                 clear;
    logic                 wr;
    logic [HDR_POS_W-1:0] pos;
    logic [7:0]           data;
  } hdr_wr_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] chk_a;
    logic [31:0] len_a;
    logic [31:0] chk_b;
    logic [31:0] len_b;
    logic [31:0] off_b;
  } hdr_info_t;

  typedef struct packed {
    logic       check;
    logic [7:0] value;
  } hdr_expect_t;

  // Fixed header bytes: version all ones, count 2, ids "OTA1"/"OTA2"
  function automatic hdr_expect_t hdr_expect(logic [HDR_POS_W-1:0] pos);
    hdr_expect_t e;
    e.check = 1'b1;
    case (pos)
      6'd0, 6'd1, 6'd2, 6'd3: e.value = 8'hFF;
      6'd4:                   e.value = 8'h02;
      6'd5, 6'd6, 6'd7:       e.value = 8'h00;
      6'd8, 6'd32:            e.value = 8'h4F;
      6'd9, 6'd33:            e.value = 8'h54;
      6'd10, 6'd34:           e.value = 8'h41;
      6'd11:                  e.value = 8'h31;
      6'd35:                  e.value = 8'h32;
      default: begin
        e.check = 1'b0;
        e.value = 8'h00;
      end
    endcase
    return e;
  endfunction

  // Augmented CRC-16, message bits shifted in MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [16:0] c;
    c = {1'b0, crc};
    for (int i = 7; i >= 0; i--) begin
      c = {c[15:0], b[i]};
      if (c[16]) begin
        c[15:0] = c[15:0] ^ CRC_POLY;
      end
      c[16] = 1'b0;
    end
    return c[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/diusc_hdr.sv =====
`default_nettype none
module diusc_hdr (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire diusc_pkg::hdr_wr_t  hdr_wr,
  output diusc_pkg::hdr_info_t     info
);

  logic [3:0][7:0] chk_a;
  logic [3:0][7:0] len_a;
  logic [3:0][7:0] chk_b;
  logic [3:0][7:0] len_b;
  logic [3:0][7:0] off_b;
  logic            bad;
  logic            bad_next;

  diusc_pkg::hdr_expect_t exp_byte;

  assign exp_byte = diusc_pkg::hdr_expect(hdr_wr.pos);

  always_comb begin
    bad_next = bad;
    if (hdr_wr.clear) begin
      bad_next = 1'b0;
    end else if (hdr_wr.wr && exp_byte.check && (hdr_wr.data != exp_byte.value)) begin
      bad_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad <= 1'b0;
    end else begin
      bad <= bad_next;
    end
  end

  // field capture, no reset: every byte is written before it is used
  always_ff @(posedge clk) begin
    if (hdr_wr.wr) begin
      case (hdr_wr.pos[5:2])
        diusc_pkg::WORD_CHK_A: chk_a[hdr_wr.pos[1:0]] <= hdr_wr.data;
        diusc_pkg::WORD_LEN_A: len_a[hdr_wr.pos[1:0]] <= hdr_wr.data;
        diusc_pkg::WORD_CHK_B: chk_b[hdr_wr.pos[1:0]] <= hdr_wr.data;
        diusc_pkg::WORD_LEN_B: len_b[hdr_wr.pos[1:0]] <= hdr_wr.data;
        diusc_pkg::WORD_OFF_B: off_b[hdr_wr.pos[1:0]] <= hdr_wr.data;
        default: ;
      endcase
    end
  end

  assign info.ok    = !bad && (chk_a != '0) && (chk_b != '0);
  assign info.chk_a = chk_a;
  assign info.len_a = len_a;
  assign info.chk_b = chk_b;
  assign info.len_b = len_b;
  assign info.off_b = off_b;

endmodule
`default_nettype wire

// ===== hw/rtl/dual_image_update_stream_checker.sv =====
`default_nettype none
// Dual image update stream checker. Each input beat carries a request kind in
// s_axis_tuser (start session, data byte, finish) and a byte in s_axis_tdata.
// The first 56 data bytes form a little-endian header: version all ones, image
// count 2, ids "OTA1"/"OTA2", both checksums nonzero. After a good header only
// the bytes of the image picked by target_image are flagged for flash (image A
// below image B's stream offset, image B from it on), with a partition offset.
// CRC-16 (0x1021, augmented) and a 32-bit byte sum cover the first img_len
// routed bytes; finish appends two zero bytes and reports the verdict in status.
// Every input beat yields exactly one output beat. Throughput is one beat per
// clock unless the output stalls; a beat passes the input register, then the
// result register, which loads together with the session state. target_image
// is only sampled when a beat is processed, so write it while the block is idle.
module dual_image_update_stream_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,      // target_image
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [23:0] write_offset, [31:24] write_byte,
                                           // [33:32] status, [34] header_done,
                                           // [50:35] crc_value, [55:51] zero
  output logic             m_axis_tuser    // [0] flash_write
);

  localparam int RW = diusc_pkg::ROUTE_W;

  // config
  logic target_image;

  // input register
  logic       in_valid;
  logic [1:0] in_req;
  logic [7:0] in_byte;
  logic       adv;

  // session state
  logic [31:0]   stream_count, stream_count_next;
  logic [RW-1:0] routed_count, routed_count_next;
  logic          header_failed, header_failed_next;
  logic [15:0]   running_crc, running_crc_next;
  logic [31:0]   byte_sum, byte_sum_next;

  // result
  logic                          res_write;
  logic [diusc_pkg::OFFSET_W-1:0] res_offset;
  logic [7:0]                    res_byte;
  diusc_pkg::status_t            res_status;

  // output register
  logic       out_valid;
  logic       out_write;
  logic [50:0] out_data;

  diusc_pkg::hdr_wr_t   hdr_wr;
  diusc_pkg::hdr_info_t info;

  logic        in_header;
  logic        take;
  logic [31:0] img_len;
  logic [31:0] img_chk;
  logic [63:0] routed_wide;
  logic [15:0] crc_fin;

  diusc_hdr u_hdr (
    .clk    (clk),
    .rst    (rst),
    .hdr_wr (hdr_wr),
    .info   (info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_image <= 1'b0;
    end else if (cfg_we) begin
      target_image <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- input stage
  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  // ---------------------------------------------------------------- processing
  assign in_header   = stream_count < 32'(diusc_pkg::HDR_BYTES);
  assign img_len     = target_image ? info.len_b : info.len_a;
  assign img_chk     = target_image ? info.chk_b : info.chk_a;
  assign take        = target_image ? (stream_count >= info.off_b)
                                    : (stream_count < info.off_b);
  assign routed_wide = 64'(routed_count);
  assign crc_fin     = diusc_pkg::crc_byte(diusc_pkg::crc_byte(running_crc, 8'h00), 8'h00);

  always_comb begin
    stream_count_next  = stream_count;
    routed_count_next  = routed_count;
    header_failed_next = header_failed;
    running_crc_next   = running_crc;
    byte_sum_next      = byte_sum;
    res_write          = 1'b0;
    res_offset         = '0;
    res_byte           = 8'h00;
    res_status         = diusc_pkg::ST_OK;
    hdr_wr.clear       = 1'b0;
    hdr_wr.wr          = 1'b0;
    hdr_wr.pos         = stream_count[diusc_pkg::HDR_POS_W-1:0];
    hdr_wr.data        = in_byte;

    if (adv) begin
      case (diusc_pkg::req_t'(in_req))
        diusc_pkg::REQ_START: begin
          stream_count_next  = '0;
          routed_count_next  = '0;
          header_failed_next = 1'b0;
          running_crc_next   = '0;
          byte_sum_next      = '0;
          hdr_wr.clear       = 1'b1;
        end
        diusc_pkg::REQ_DATA: begin
          if (!header_failed) begin
            if (in_header) begin
              hdr_wr.wr = 1'b1;
              // last header byte: all checked bytes already seen
              if (stream_count == 32'(diusc_pkg::HDR_BYTES - 1)) begin
                header_failed_next = !info.ok;
              end
            end else if (take && !routed_count[RW-1]) begin
              res_write  = 1'b1;
              res_offset = routed_wide[diusc_pkg::OFFSET_W-1:0];
              res_byte   = in_byte;
              if (routed_wide < 64'(img_len)) begin
                running_crc_next = diusc_pkg::crc_byte(running_crc, in_byte);
                byte_sum_next    = byte_sum + 32'(in_byte);
              end
              routed_count_next = routed_count + RW'(1);
            end
            if (stream_count != '1) begin
              stream_count_next = stream_count + 32'd1;
            end
          end
        end
        diusc_pkg::REQ_FINISH: begin
          if (header_failed || in_header) begin
            res_status = diusc_pkg::ST_HDR_BAD;
          end else begin
            running_crc_next = crc_fin;
            if (crc_fin == 16'h0000) begin
              res_status = diusc_pkg::ST_CRC_ZERO;
            end else if (img_chk != byte_sum) begin
              res_status = diusc_pkg::ST_SUM_BAD;
            end else begin
              res_status = diusc_pkg::ST_OK;
            end
          end
        end
        default: ;
      endcase

      if (diusc_pkg::req_t'(in_req) != diusc_pkg::REQ_FINISH) begin
        res_status = header_failed_next ? diusc_pkg::ST_HDR_BAD : diusc_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_count  <= '0;
      routed_count  <= '0;
      header_failed <= 1'b0;
      running_crc   <= '0;
      byte_sum      <= '0;
    end else begin
      stream_count  <= stream_count_next;
      routed_count  <= routed_count_next;
      header_failed <= header_failed_next;
      running_crc   <= running_crc_next;
      byte_sum      <= byte_sum_next;
    end
  end

  // ---------------------------------------------------------------- output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_write <= res_write;
      out_data  <= {running_crc_next,
                    (stream_count_next >= 32'(diusc_pkg::HDR_BYTES)),
                    res_status,
                    res_byte,
                    res_offset};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_write;
  assign m_axis_tdata  = {5'b00000, out_data};

  // ---------------------------------------------------------------- assertions
  // a flash write only ever follows a complete header
  a_write_after_hdr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[34])
    else $error("flash write before header complete");

  // a rejected header freezes the stream position right after the header
  a_fail_count: assert property (@(posedge clk) disable iff (rst)
    header_failed |-> stream_count == 32'(diusc_pkg::HDR_BYTES))
    else $error("stream count moved after header rejection");

  // nothing is routed while the header is still coming in
  a_no_route_in_hdr: assert property (@(posedge clk) disable iff (rst)
    in_header |-> routed_count == '0)
    else $error("bytes routed during header");

  // routed counter stops exactly at partition size
  a_route_limit: assert property (@(posedge clk) disable iff (rst)
    routed_count[RW-1] |-> routed_count[RW-2:0] == '0)
    else $error("routed count beyond partition size");

  // each processed beat shows up at the output in the next cycle
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_axis_tvalid)
    else $error("processed beat missing at output");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Local view of the update format
  localparam int          HDR_LEN      = 56;
  localparam logic [15:0] POLY         = 16'h1021;
  localparam logic [24:0] PART_FULL    = 25'h1000000;  // 2^24 routed bytes
  localparam logic [31:0] VERSION_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_WORD   = 32'd2;
  localparam logic [31:0] ID_A_WORD    = 32'h3141_544F;  // "OTA1" as stored, LE
  localparam logic [31:0] ID_B_WORD    = 32'h3241_544F;  // "OTA2"
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;           // no meaning, must be ignored
  localparam int          DRAIN_CYCLES = 4;              // two-stage pipe plus margin
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 10;

  // One output beat, split into its fields
  typedef struct packed {
    logic        flash_write;
    logic [23:0] write_offset;
    logic [7:0]  write_byte;
    logic [1:0]  status;
    logic        header_done;
    logic [15:0] crc_value;
  } update_result_t;

  // DUT connections; every input has a known value from time zero
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic        cfg_wdata     = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire logic   s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser  = 2'd0;    // [1:0] req_type
  wire logic   m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire logic [55:0] m_axis_tdata;       // [23:0] write_offset, [31:24] write_byte,
                                        // [33:32] status, [34] header_done,
                                        // [50:35] crc_value, [55:51] zero
  wire logic   m_axis_tuser;            // [0] flash_write

  dual_image_update_stream_checker u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Predicted session state (mirrors what the block should hold)
  logic [7:0]  hdr_bytes [HDR_LEN];
  logic [31:0] stream_pos   = '0;
  logic [24:0] routed_bytes = '0;
  logic        hdr_rejected = 1'b0;
  logic [15:0] image_crc    = '0;
  logic [31:0] image_sum    = '0;
  logic        target_sel   = 1'b0;

  update_result_t expected_updates [$];
  logic [7:0]     update_stream [$];    // header + payload of the session being built

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int beats_sent      = 0;
  int results_checked = 0;
  int sessions_run    = 0;
  int mismatches      = 0;
  int cycles          = 0;
  int finish_verdicts [4] = '{0, 0, 0, 0};

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d results outstanding",
               cycles, expected_updates.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] stored_word(int pos);
    return {hdr_bytes[pos+3], hdr_bytes[pos+2], hdr_bytes[pos+1], hdr_bytes[pos]};
  endfunction

  // Augmented CRC: one byte in, MSB first, no reflection
  function automatic logic [15:0] crc16_shift(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15];
      crc = {crc[14:0], b[i]};
      if (fb) crc = crc ^ POLY;
    end
    return crc;
  endfunction

  function automatic logic header_valid();
    return stored_word(0) == VERSION_WORD && stored_word(4) == COUNT_WORD &&
           stored_word(8) == ID_A_WORD && stored_word(32) == ID_B_WORD &&
           stored_word(16) != 0 && stored_word(40) != 0;
  endfunction

  function automatic void clear_session();
    for (int i = 0; i < HDR_LEN; i++) hdr_bytes[i] = 8'h00;
    stream_pos   = '0;
    routed_bytes = '0;
    hdr_rejected = 1'b0;
    image_crc    = '0;
    image_sum    = '0;
  endfunction

  // Advances the predicted state by one accepted request and returns its result
  function automatic update_result_t predict_update(logic [1:0] req, logic [7:0] b);
    update_result_t r;
    logic [31:0]    off_b;
    logic [31:0]    img_len;
    logic           take;
    r = '0;
    if (req == diusc_pkg::REQ_START) begin
      clear_session();
    end else if (req == diusc_pkg::REQ_DATA) begin
      if (!hdr_rejected) begin
        if (stream_pos < HDR_LEN) begin
          hdr_bytes[stream_pos[5:0]] = b;
          if (stream_pos == HDR_LEN - 1) hdr_rejected = !header_valid();
        end else begin
          off_b = stored_word(48);
          take  = target_sel ? (stream_pos >= off_b) : (stream_pos < off_b);
          if (take && routed_bytes < PART_FULL) begin
            img_len        = stored_word(target_sel ? 44 : 20);
            r.flash_write  = 1'b1;
            r.write_offset = routed_bytes[23:0];
            r.write_byte   = b;
            // bytes past img_len still go to flash but stay out of crc/sum
            if ({7'd0, routed_bytes} < img_len) begin
              image_crc = crc16_shift(image_crc, b);
              image_sum = image_sum + b;
            end
            routed_bytes++;
          end
        end
        if (stream_pos != '1) stream_pos++;
      end
    end else if (req == diusc_pkg::REQ_FINISH) begin
      if (hdr_rejected || stream_pos < HDR_LEN) begin
        r.status = diusc_pkg::ST_HDR_BAD;
      end else begin
        // each finish appends two more zero bytes
        image_crc = crc16_shift(crc16_shift(image_crc, 8'h00), 8'h00);
        if (image_crc == 0) r.status = diusc_pkg::ST_CRC_ZERO;
        else if (stored_word(target_sel ? 40 : 16) != image_sum)
          r.status = diusc_pkg::ST_SUM_BAD;
        else r.status = diusc_pkg::ST_OK;
      end
      finish_verdicts[r.status]++;
    end
    if (req != diusc_pkg::REQ_FINISH)
      r.status = hdr_rejected ? diusc_pkg::ST_HDR_BAD : diusc_pkg::ST_OK;
    r.header_done = (stream_pos >= HDR_LEN);
    r.crc_value   = image_crc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("tb_top: result %0d %s mismatch: expected 0x%0h, got 0x%0h",
                 results_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    update_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb_top: result beat with nothing expected (tdata 0x%0h)", m_axis_tdata);
      end else begin
        want = expected_updates.pop_front();
        compare_field("flash_write", want.flash_write, m_axis_tuser);
        compare_field("write_offset", want.write_offset, m_axis_tdata[23:0]);
        compare_field("write_byte", want.write_byte, m_axis_tdata[31:24]);
        compare_field("status", want.status, m_axis_tdata[33:32]);
        compare_field("header_done", want.header_done, m_axis_tdata[34]);
        compare_field("crc_value", want.crc_value, m_axis_tdata[50:35]);
        compare_field("pad bits", 32'd0, m_axis_tdata[55:51]);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plumbing
  // ---------------------------------------------------------------------------
  // One input beat; random sender gaps ahead of it, prediction on acceptance
  task automatic send_beat(input logic [1:0] req, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_updates.push_back(predict_update(req, b));
    beats_sent++;
  endtask

  // Block idle: no beat in flight and the pipe flushed
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic value);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    target_sel = value;
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) update_stream.push_back(w[8*i +: 8]);
  endtask

  // Builds a well-formed session: header, then n_a bytes of image A and n_b of
  // image B. Checksums follow the routing the given off_b produces; bad_sum
  // skews both by one.
  task automatic build_update(input int n_a, input int n_b, input logic [31:0] len_a,
                              input logic [31:0] len_b, input logic [31:0] off_b,
                              input bit zero_fill, input bit bad_sum);
    logic [7:0]  body [$];
    logic [31:0] sum_a, sum_b, cnt_a, cnt_b;
    sum_a = '0;
    sum_b = '0;
    cnt_a = '0;
    cnt_b = '0;
    for (int i = 0; i < n_a + n_b; i++) body.push_back(zero_fill ? 8'h00 : 8'($urandom));
    for (int i = 0; i < n_a + n_b; i++) begin
      if (HDR_LEN + i < off_b) begin
        if (cnt_a < len_a) sum_a += body[i];
        cnt_a++;
      end else begin
        if (cnt_b < len_b) sum_b += body[i];
        cnt_b++;
      end
    end
    if (bad_sum) begin
      sum_a++;
      sum_b++;
    end
    // a zero checksum would reject the header; keep it nonzero
    if (sum_a == 0) sum_a = 32'd1;
    if (sum_b == 0) sum_b = 32'd1;
    update_stream.delete();
    push_word(VERSION_WORD);
    push_word(COUNT_WORD);
    push_word(ID_A_WORD);
    push_word($urandom);
    push_word(sum_a);
    push_word(len_a);
    push_word($urandom);
    push_word($urandom);
    push_word(ID_B_WORD);
    push_word($urandom);
    push_word(sum_b);
    push_word(len_b);
    push_word(off_b);
    push_word($urandom);
    foreach (body[i]) update_stream.push_back(body[i]);
  endtask

  // Streams update_stream[first..last-1], with occasional unused-code beats mixed in
  task automatic stream_bytes(input int first, input int last, input int noise_pct);
    for (int i = first; i < last; i++) begin
      if ($urandom_range(99) < noise_pct) send_beat(REQ_UNUSED, 8'($urandom));
      send_beat(diusc_pkg::REQ_DATA, update_stream[i]);
    end
  endtask

  task automatic start_and_stream(input int noise_pct);
    send_beat(diusc_pkg::REQ_START, 8'($urandom));
    stream_bytes(0, update_stream.size(), noise_pct);
    sessions_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------
  // Unused code from reset, finish with no or partial header
  task automatic test_request_codes();
    send_beat(REQ_UNUSED, 8'hFF);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
    send_beat(diusc_pkg::REQ_START, 8'hA5);
    send_beat(diusc_pkg::REQ_DATA, 8'h00);
    send_beat(diusc_pkg::REQ_DATA, 8'hFF);
    send_beat(diusc_pkg::REQ_FINISH, 8'h5A);
    send_beat(diusc_pkg::REQ_DATA, 8'h80);
    send_beat(REQ_UNUSED, 8'h00);
  endtask

  // Image A with bytes past img_len, then a repeated finish
  task automatic test_image_a_routing();
    write_target(1'b0);
    build_update(6, 3, 32'd4, 32'd3, HDR_LEN + 6, 1'b0, 1'b0);
    start_and_stream(0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
    send_beat(diusc_pkg::REQ_FINISH, 8'hFF);
  endtask

  task automatic test_image_b_sum_mismatch();
    write_target(1'b1);
    build_update(3, 5, 32'd3, 32'd5, HDR_LEN + 3, 1'b0, 1'b1);
    start_and_stream(0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
  endtask

  // All-zero image and zero-length image both finish with a zero CRC
  task automatic test_crc_zero();
    write_target(1'b0);
    build_update(4, 2, 32'd4, 32'd2, HDR_LEN + 4, 1'b1, 1'b0);
    start_and_stream(0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
    build_update(3, 3, 32'd0, 32'd3, HDR_LEN + 3, 1'b0, 1'b0);
    start_and_stream(0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
  endtask

  // Bad version byte, then a zero image B checksum: payload must be ignored
  task automatic test_rejected_header();
    build_update(3, 3, 32'd3, 32'd3, HDR_LEN + 3, 1'b0, 1'b0);
    update_stream[0] ^= 8'h01;
    start_and_stream(0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
    build_update(3, 3, 32'd3, 32'd3, HDR_LEN + 3, 1'b0, 1'b0);
    for (int i = 40; i < 44; i++) update_stream[i] = 8'h00;
    start_and_stream(0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
  endtask

  // Image B offset inside the header: A is empty, B takes everything
  task automatic test_offset_in_header();
    write_target(1'b1);
    build_update(0, 8, 32'd0, 32'd8, 32'd8, 1'b0, 1'b0);
    start_and_stream(0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
    write_target(1'b0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
  endtask

  // Target flipped from A to B after the first two B bytes of one session; B len all ones
  task automatic test_target_switch();
    write_target(1'b0);
    build_update(5, 5, 32'd5, 32'hFFFF_FFFF, HDR_LEN + 5, 1'b0, 1'b0);
    send_beat(diusc_pkg::REQ_START, 8'h00);
    stream_bytes(0, HDR_LEN + 7, 0);
    write_target(1'b1);
    stream_bytes(HDR_LEN + 7, update_stream.size(), 0);
    send_beat(diusc_pkg::REQ_FINISH, 8'h00);
    sessions_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Random sessions
  // ---------------------------------------------------------------------------
  task automatic run_random_session();
    int          n_a, n_b, kind, pos, split;
    logic [31:0] len_a, len_b, off_b;
    n_a   = $urandom_range(0, 40);
    n_b   = $urandom_range(0, 40);
    len_a = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 48);
    len_b = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 48);
    off_b = HDR_LEN + n_a;
    if ($urandom_range(9) == 0)
      off_b = ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, HDR_LEN + 80);
    build_update(n_a, n_b, len_a, len_b, off_b, $urandom_range(19) == 0,
                 $urandom_range(3) == 0);

    // most sessions stay well-formed; the rest break the header or stop short
    kind = $urandom_range(99);
    if (kind < 8) begin
      pos = $urandom_range(0, 15);
      if (pos >= 12) pos += 20;                      // fixed bytes: 0..11, 32..35
      update_stream[pos] ^= 8'h01 << $urandom_range(7);
    end else if (kind < 12) begin
      pos = ($urandom_range(1) == 0) ? 16 : 40;      // zero one checksum word
      for (int i = 0; i < 4; i++) update_stream[pos+i] = 8'h00;
    end else if (kind < 18) begin
      split = $urandom_range(0, update_stream.size() - 1);
      while (update_stream.size() > split) void'(update_stream.pop_back());
    end

    if ($urandom_range(9) != 0) send_beat(diusc_pkg::REQ_START, 8'($urandom));
    if ($urandom_range(9) == 0) begin
      split = $urandom_range(0, update_stream.size());
      stream_bytes(0, split, 3);
      write_target(!target_sel);
      stream_bytes(split, update_stream.size(), 3);
    end else begin
      stream_bytes(0, update_stream.size(), 3);
    end
    repeat ($urandom_range(1, 3)) send_beat(diusc_pkg::REQ_FINISH, 8'($urandom));
    // a few stray bytes after finish keep feeding the same session
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 4)) send_beat(diusc_pkg::REQ_DATA, 8'($urandom));
    sessions_run++;
  endtask

  task automatic test_random_updates(input int send_pct, input int recv_pct, input int beats);
    int phase_end;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    phase_end     = beats_sent + beats;
    while (beats_sent < phase_end) begin
      if ($urandom_range(9) < 3) write_target(1'($urandom_range(1)));
      run_random_session();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_session();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 12;
    recv_idle_pct = 47;
    test_request_codes();
    test_image_a_routing();
    test_image_b_sum_mismatch();
    test_crc_zero();
    test_rejected_header();
    test_offset_in_header();
    test_target_switch();

    test_random_updates(12, 47, 420);
    test_random_updates(47, 12, 420);
    test_random_updates(0, 0, 420);

    wait_drain();
    if (expected_updates.size() != 0) begin
      $display("tb_top: %0d expected results never arrived", expected_updates.size());
      mismatches += expected_updates.size();
    end
    $display("tb_top: %0d beats over %0d sessions, %0d results checked, %0d mismatches",
             beats_sent, sessions_run, results_checked, mismatches);
    $display("tb_top: finish verdicts ok=%0d hdr_bad=%0d crc_zero=%0d sum_bad=%0d",
             finish_verdicts[diusc_pkg::ST_OK], finish_verdicts[diusc_pkg::ST_HDR_BAD],
             finish_verdicts[diusc_pkg::ST_CRC_ZERO], finish_verdicts[diusc_pkg::ST_SUM_BAD]);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
